// ===== rtl/tsu_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tsu_pkg
// Types, codes and the dispatch table shared by the Thumb-16 store unit.
// ----------------------------------------------------------------------------
package tsu_pkg;

    localparam int XLEN      = 32;
    localparam int NUM_LOW   = 8;
    localparam int LOW_IDX_W = 3;

    localparam logic [3:0] REG_SP = 4'd8;
    localparam logic [3:0] REG_LR = 4'd9;

    localparam logic [4:0] OP5_STR_IMM  = 5'b01100;
    localparam logic [4:0] OP5_STR_SP   = 5'b10010;
    localparam logic [4:0] OP5_STRB_IMM = 5'b01110;
    localparam logic [4:0] OP5_STRH_IMM = 5'b10000;
    localparam logic [6:0] OP7_STRB_REG = 7'b0101010;
    localparam logic [6:0] OP7_STRH_REG = 7'b0101001;
    localparam logic [6:0] OP7_PUSH     = 7'b1011010;

    typedef struct packed {
        logic        func;
        logic [3:0]  reg_index;
        logic [31:0] reg_value;
        logic [15:0] instruction;
        logic [31:0] pc_value;
    } t_in;

    typedef struct packed {
        logic [31:0] store_address;
        logic [31:0] store_data;
        logic [1:0]  store_size;
        logic        cache_invalidate;
        logic [31:0] next_pc;
        logic [31:0] stack_after;
        logic [1:0]  error_code;
        logic        last;
    } t_out;

    typedef enum logic [1:0] {
        ERR_OK    = 2'd0,
        ERR_BAD   = 2'd1,
        ERR_EMPTY = 2'd2
    } t_err;

    typedef enum logic [3:0] {
        U_STR_IMM_RD  = 4'd0,
        U_STR_IMM_EX  = 4'd1,
        U_STR_SP_RD   = 4'd2,
        U_STR_SP_EX   = 4'd3,
        U_STRB_IMM_RD = 4'd4,
        U_STRB_IMM_EX = 4'd5,
        U_STRH_IMM_RD = 4'd6,
        U_STRH_IMM_EX = 4'd7,
        U_REG_RD      = 4'd8,
        U_REG_SUM     = 4'd9,
        U_REG_EX      = 4'd10,
        U_BAD         = 4'd11,
        U_PUSH_EMPTY  = 4'd12,
        U_PUSH_LR     = 4'd13,
        U_PUSH_PREP   = 4'd14,
        U_PUSH_REG    = 4'd15
    } t_upc;

    typedef enum logic [1:0] {
        RA_NONE = 2'd0,
        RA_RN   = 2'd1,
        RA_RT   = 2'd2
    } t_ra_sel;

    typedef enum logic [2:0] {
        RB_NONE = 3'd0,
        RB_RM   = 3'd1,
        RB_RT   = 3'd2,
        RB_RTHI = 3'd3,
        RB_TOP  = 3'd4
    } t_rb_sel;

    typedef enum logic [2:0] {
        BS_ZERO  = 3'd0,
        BS_RA    = 3'd1,
        BS_SP    = 3'd2,
        BS_PADDR = 3'd3,
        BS_ADDR  = 3'd4
    } t_base;

    typedef enum logic [2:0] {
        OF_ZERO    = 3'd0,
        OF_IMM5X4  = 3'd1,
        OF_IMM8X4  = 3'd2,
        OF_IMM5    = 3'd3,
        OF_IMM5X2  = 3'd4,
        OF_RB      = 3'd5
    } t_off;

    typedef enum logic [1:0] {
        D_ZERO = 2'd0,
        D_RA   = 2'd1,
        D_RB   = 2'd2,
        D_LR   = 2'd3
    } t_dsel;

    typedef enum logic [2:0] {
        SZ_NONE  = 3'd0,
        SZ_BYTE  = 3'd1,
        SZ_HALF  = 3'd2,
        SZ_WORD  = 3'd3,
        SZ_BY_OP = 3'd4
    } t_sz;

    typedef enum logic [1:0] {
        C_NEXT = 2'd0,
        C_END  = 2'd1,
        C_LOOP = 2'd2
    } t_cond;

    typedef struct packed {
        logic    emit;
        t_ra_sel ra;
        t_rb_sel rb;
        t_base   base;
        t_off    off;
        t_dsel   dsel;
        t_sz     size;
        logic    inval;
        t_err    err;
        logic    lat_addr;
        logic    pop;
        logic    sp_wr;
        t_cond   cond;
        t_upc    next;
    } t_uop;

    typedef struct packed {
        logic accept;
        logic exec;
        logic ends;
        t_uop uop;
    } t_ctl;

    typedef struct packed {
        logic slot_free;
        logic mask_next_zero;
    } t_dp_stat;

    function automatic t_upc dispatch(input logic [15:0] ins);
        t_upc e;
        begin
            e = U_BAD;
            if (ins[15:11] == OP5_STR_IMM) begin
                e = U_STR_IMM_RD;
            end else if (ins[15:11] == OP5_STR_SP) begin
                e = U_STR_SP_RD;
            end else if (ins[15:11] == OP5_STRB_IMM) begin
                e = U_STRB_IMM_RD;
            end else if (ins[15:9] == OP7_STRB_REG) begin
                e = U_REG_RD;
            end else if (ins[15:11] == OP5_STRH_IMM) begin
                e = U_STRH_IMM_RD;
            end else if (ins[15:9] == OP7_STRH_REG) begin
                e = U_REG_RD;
            end else if (ins[15:9] == OP7_PUSH) begin
                if (ins[8:0] == 9'd0) begin
                    e = U_PUSH_EMPTY;
                end else if (ins[8]) begin
                    e = U_PUSH_LR;
                end else begin
                    e = U_PUSH_PREP;
                end
            end
            return e;
        end
    endfunction

endpackage
`default_nettype wire

// ===== rtl/tsu_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tsu_ram
// Generic RAM, one write port and two registered read ports.
// ----------------------------------------------------------------------------
module tsu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re_a,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_a,
    output logic      [WIDTH-1:0]         o_rdata_a,
    input  wire logic                     i_re_b,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic      [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re_a) begin
            r_rdata_a <= r_mem[i_raddr_a];
        end
        if (i_re_b) begin
            r_rdata_b <= r_mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule
`default_nettype wire

// ===== rtl/tsu_seq.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tsu_seq
// Microcode sequencer: program counter, control store and dispatch.
// ----------------------------------------------------------------------------
module tsu_seq (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    input  wire logic               i_func,
    input  wire logic [15:0]        i_instruction,
    input  wire tsu_pkg::t_dp_stat  i_stat,
    output logic                    o_busy,
    output tsu_pkg::t_ctl           o_ctl
);
    import tsu_pkg::*;

    logic r_busy;
    t_upc r_upc;
    t_upc n_upc;
    t_uop uop;
    logic accept;
    logic exec;
    logic ends;

    function automatic t_uop ucode(input t_upc pc);
        t_uop u;
        begin
            u = '0;
            unique case (pc) inside
                U_STR_IMM_RD, U_STRB_IMM_RD, U_STRH_IMM_RD: begin
                    u.ra   = RA_RN;
                    u.rb   = RB_RT;
                    u.cond = C_NEXT;
                    u.next = t_upc'(pc + 4'd1);
                end
                U_STR_IMM_EX: begin
                    u.emit = 1'b1;
                    u.base = BS_RA;
                    u.off  = OF_IMM5X4;
                    u.dsel = D_RB;
                    u.size = SZ_WORD;
                    u.cond = C_END;
                end
                U_STR_SP_RD: begin
                    u.rb   = RB_RTHI;
                    u.cond = C_NEXT;
                    u.next = U_STR_SP_EX;
                end
                U_STR_SP_EX: begin
                    u.emit = 1'b1;
                    u.base = BS_SP;
                    u.off  = OF_IMM8X4;
                    u.dsel = D_RB;
                    u.size = SZ_WORD;
                    u.cond = C_END;
                end
                U_STRB_IMM_EX: begin
                    u.emit = 1'b1;
                    u.base = BS_RA;
                    u.off  = OF_IMM5;
                    u.dsel = D_RB;
                    u.size = SZ_BYTE;
                    u.cond = C_END;
                end
                U_STRH_IMM_EX: begin
                    u.emit = 1'b1;
                    u.base = BS_RA;
                    u.off  = OF_IMM5X2;
                    u.dsel = D_RB;
                    u.size = SZ_HALF;
                    u.cond = C_END;
                end
                U_REG_RD: begin
                    u.ra   = RA_RN;
                    u.rb   = RB_RM;
                    u.cond = C_NEXT;
                    u.next = U_REG_SUM;
                end
                U_REG_SUM: begin
                    u.base     = BS_RA;
                    u.off      = OF_RB;
                    u.lat_addr = 1'b1;
                    u.ra       = RA_RT;
                    u.cond     = C_NEXT;
                    u.next     = U_REG_EX;
                end
                U_REG_EX: begin
                    u.emit = 1'b1;
                    u.base = BS_ADDR;
                    u.off  = OF_ZERO;
                    u.dsel = D_RA;
                    u.size = SZ_BY_OP;
                    u.cond = C_END;
                end
                U_BAD: begin
                    u.emit = 1'b1;
                    u.err  = ERR_BAD;
                    u.cond = C_END;
                end
                U_PUSH_EMPTY: begin
                    u.emit = 1'b1;
                    u.err  = ERR_EMPTY;
                    u.cond = C_END;
                end
                U_PUSH_LR: begin
                    u.emit  = 1'b1;
                    u.base  = BS_PADDR;
                    u.dsel  = D_LR;
                    u.size  = SZ_WORD;
                    u.inval = 1'b1;
                    u.rb    = RB_TOP;
                    u.sp_wr = 1'b1;
                    u.cond  = C_LOOP;
                    u.next  = U_PUSH_REG;
                end
                U_PUSH_PREP: begin
                    u.rb   = RB_TOP;
                    u.cond = C_NEXT;
                    u.next = U_PUSH_REG;
                end
                U_PUSH_REG: begin
                    u.emit  = 1'b1;
                    u.base  = BS_PADDR;
                    u.dsel  = D_RB;
                    u.size  = SZ_WORD;
                    u.inval = 1'b1;
                    u.pop   = 1'b1;
                    u.rb    = RB_TOP;
                    u.sp_wr = 1'b1;
                    u.cond  = C_LOOP;
                    u.next  = U_PUSH_REG;
                end
            endcase
            return u;
        end
    endfunction

    assign uop    = ucode(r_upc);
    assign accept = i_in_valid && !r_busy;
    assign exec   = r_busy && (!uop.emit || i_stat.slot_free);
    assign ends   = (uop.cond == C_END) || ((uop.cond == C_LOOP) && i_stat.mask_next_zero);

    always_comb begin
        n_upc = r_upc;
        if (accept && i_func) begin
            n_upc = dispatch(i_instruction);
        end else if (exec && !ends) begin
            n_upc = uop.next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (accept && i_func) begin
            r_busy <= 1'b1;
        end else if (exec && ends) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc <= U_BAD;
        end else begin
            r_upc <= n_upc;
        end
    end

    assign o_busy      = r_busy;
    assign o_ctl.accept = accept;
    assign o_ctl.exec   = exec;
    assign o_ctl.ends   = ends;
    assign o_ctl.uop    = uop;

endmodule
`default_nettype wire

// ===== rtl/tsu_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tsu_datapath
// Register file, address adder, push bookkeeping and the result register.
// ----------------------------------------------------------------------------
module tsu_datapath (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire tsu_pkg::t_in      i_in,
    input  wire tsu_pkg::t_ctl     i_ctl,
    input  wire logic              i_out_stall,
    output tsu_pkg::t_dp_stat      o_stat,
    output logic                   o_out_valid,
    output tsu_pkg::t_out          o_out
);
    import tsu_pkg::*;

    logic [15:0]          r_ins;
    logic [XLEN-1:0]      r_npc;
    logic [XLEN-1:0]      r_sp;
    logic [XLEN-1:0]      r_lr;
    logic [XLEN-1:0]      r_sp_after;
    logic [XLEN-1:0]      r_paddr;
    logic [XLEN-1:0]      r_addr;
    logic [NUM_LOW-1:0]   r_mask;
    logic [NUM_LOW-1:0]   r_valid;
    logic                 r_va;
    logic                 r_vb;
    logic                 r_out_valid;
    t_out                 r_out;

    t_uop                 uop;
    logic                 wr_low;
    logic                 re_a;
    logic                 re_b;
    logic [LOW_IDX_W-1:0] raddr_a;
    logic [LOW_IDX_W-1:0] raddr_b;
    logic [XLEN-1:0]      rdata_a;
    logic [XLEN-1:0]      rdata_b;
    logic [XLEN-1:0]      ra_v;
    logic [XLEN-1:0]      rb_v;
    logic [NUM_LOW-1:0]   n_mask;
    logic [XLEN-1:0]      base_v;
    logic [XLEN-1:0]      off_v;
    logic [XLEN-1:0]      sum;
    logic [XLEN-1:0]      data_v;
    logic [1:0]           size_v;
    logic [3:0]           push_cnt;
    logic                 is_push;
    logic                 emit;
    t_out                 n_out;

    function automatic logic [LOW_IDX_W-1:0] top_idx(input logic [NUM_LOW-1:0] m);
        logic [LOW_IDX_W-1:0] idx;
        begin
            idx = '0;
            for (int i = 0; i < NUM_LOW; i++) begin
                if (m[i]) begin
                    idx = LOW_IDX_W'(i);
                end
            end
            return idx;
        end
    endfunction

    function automatic logic [3:0] count9(input logic [8:0] v);
        logic [3:0] c;
        begin
            c = '0;
            for (int i = 0; i < 9; i++) begin
                c = c + 4'(v[i]);
            end
            return c;
        end
    endfunction

    assign uop    = i_ctl.uop;
    assign emit   = i_ctl.exec && uop.emit;
    assign wr_low = i_ctl.accept && !i_in.func && (i_in.reg_index < 4'(NUM_LOW));

    // register file reads
    always_comb begin
        re_a    = i_ctl.exec && (uop.ra != RA_NONE);
        re_b    = i_ctl.exec && (uop.rb != RB_NONE);
        raddr_a = r_ins[5:3];
        raddr_b = r_ins[2:0];
        case (uop.ra)
            RA_RT:   raddr_a = r_ins[2:0];
            default: raddr_a = r_ins[5:3];
        endcase
        case (uop.rb)
            RB_RM:   raddr_b = r_ins[8:6];
            RB_RTHI: raddr_b = r_ins[10:8];
            RB_TOP:  raddr_b = top_idx(n_mask);
            default: raddr_b = r_ins[2:0];
        endcase
    end

    tsu_ram #(
        .WIDTH (XLEN),
        .DEPTH (NUM_LOW)
    ) u_regs (
        .i_clk     (i_clk),
        .i_we      (wr_low),
        .i_waddr   (i_in.reg_index[LOW_IDX_W-1:0]),
        .i_wdata   (i_in.reg_value),
        .i_re_a    (re_a),
        .i_raddr_a (raddr_a),
        .o_rdata_a (rdata_a),
        .i_re_b    (re_b),
        .i_raddr_b (raddr_b),
        .o_rdata_b (rdata_b)
    );

    // unwritten low registers read as zero
    assign ra_v = r_va ? rdata_a : '0;
    assign rb_v = r_vb ? rdata_b : '0;

    assign n_mask = uop.pop ? (r_mask & ~(NUM_LOW'(1) << top_idx(r_mask))) : r_mask;

    always_comb begin
        case (uop.base)
            BS_RA:    base_v = ra_v;
            BS_SP:    base_v = r_sp;
            BS_PADDR: base_v = r_paddr;
            BS_ADDR:  base_v = r_addr;
            default:  base_v = '0;
        endcase
        case (uop.off)
            OF_IMM5X4: off_v = {25'd0, r_ins[10:6], 2'b00};
            OF_IMM8X4: off_v = {22'd0, r_ins[7:0], 2'b00};
            OF_IMM5:   off_v = {27'd0, r_ins[10:6]};
            OF_IMM5X2: off_v = {26'd0, r_ins[10:6], 1'b0};
            OF_RB:     off_v = rb_v;
            default:   off_v = '0;
        endcase
        case (uop.dsel)
            D_RA:    data_v = ra_v;
            D_RB:    data_v = rb_v;
            D_LR:    data_v = r_lr;
            default: data_v = '0;
        endcase
        case (uop.size)
            SZ_BYTE:  size_v = 2'd1;
            SZ_HALF:  size_v = 2'd2;
            SZ_WORD:  size_v = 2'd3;
            SZ_BY_OP: size_v = r_ins[9] ? 2'd2 : 2'd1;
            default:  size_v = 2'd0;
        endcase
    end

    assign sum = base_v + off_v;

    always_comb begin
        n_out.store_address    = sum;
        case (size_v)
            2'd1:    n_out.store_data = {24'd0, data_v[7:0]};
            2'd2:    n_out.store_data = {16'd0, data_v[15:0]};
            2'd3:    n_out.store_data = data_v;
            default: n_out.store_data = '0;
        endcase
        n_out.store_size       = size_v;
        n_out.cache_invalidate = uop.inval;
        n_out.next_pc          = r_npc;
        n_out.stack_after      = r_sp_after;
        n_out.error_code       = uop.err;
        n_out.last             = i_ctl.ends;
    end

    assign push_cnt = count9(i_in.instruction[8:0]);
    assign is_push  = (i_in.instruction[15:9] == OP7_PUSH);

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_sp        <= '0;
            r_lr        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (wr_low) begin
                r_valid[i_in.reg_index[LOW_IDX_W-1:0]] <= 1'b1;
            end
            if (i_ctl.accept && !i_in.func && (i_in.reg_index == REG_SP)) begin
                r_sp <= i_in.reg_value;
            end else if (i_ctl.exec && i_ctl.ends && uop.sp_wr) begin
                r_sp <= r_sp_after;
            end
            if (i_ctl.accept && !i_in.func && (i_in.reg_index == REG_LR)) begin
                r_lr <= i_in.reg_value;
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (i_ctl.accept && i_in.func) begin
            r_ins      <= i_in.instruction;
            r_npc      <= i_in.pc_value + 32'd2;
            r_mask     <= i_in.instruction[7:0];
            r_paddr    <= r_sp - 32'd4;
            r_sp_after <= is_push ? (r_sp - {26'd0, push_cnt, 2'b00}) : r_sp;
        end else if (i_ctl.exec) begin
            r_mask <= n_mask;
            if (uop.emit && (uop.base == BS_PADDR)) begin
                r_paddr <= r_paddr - 32'd4;
            end
        end
        if (i_ctl.exec && uop.lat_addr) begin
            r_addr <= sum;
        end
        if (re_a) begin
            r_va <= r_valid[raddr_a];
        end
        if (re_b) begin
            r_vb <= r_valid[raddr_b];
        end
        if (emit) begin
            r_out <= n_out;
        end
    end

    assign o_stat.slot_free      = !r_out_valid || !i_out_stall;
    assign o_stat.mask_next_zero = (n_mask == '0);
    assign o_out_valid           = r_out_valid;
    assign o_out                 = r_out;

endmodule
`default_nettype wire

// ===== rtl/thumb16_store_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// thumb16_store_unit
// Thumb-16 store and push execute unit with its own R0-R7, SP and LR.
// ----------------------------------------------------------------------------
// Input channel i_in (valid/stall): func 0 loads R0-R7, SP or LR and gives no
// beat; func 1 executes the instruction and gives store beats on o_out, last
// set on the final one; a bad encoding or empty push gives one error beat.
// Microcode steps per instruction after its accept; each store step waits on the
// result register and puts one store beat in it:
//   STR/STRB/STRH immediate, STR SP-relative: a read step, then the store step
//   STRB/STRH register offset: two register file read steps, then the store step
//   PUSH: one store step per listed register, LR first; without LR a prefetch step first
//   error beat: a single step that emits it
// One instruction is in flight at a time; i_in is stalled from its accept
// until its final beat is in the result register, so the next item can be taken
// in the cycle after the final step. The first beat appears in the cycle after
// the step that makes it.
// i_out_stall holds the result register; the sequencer waits on emitting steps
// until the beat can be replaced. Reset makes R0-R7, SP and LR read as zero,
// empties the result register and leaves the sequencer idle.
// ----------------------------------------------------------------------------
module thumb16_store_unit (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_stall,
    input  wire tsu_pkg::t_in  i_in,
    output logic               o_out_valid,
    input  wire logic          i_out_stall,
    output tsu_pkg::t_out      o_out
);
    import tsu_pkg::*;

    t_ctl     ctl;
    t_dp_stat stat;
    logic     busy;

    tsu_seq u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_func        (i_in.func),
        .i_instruction (i_in.instruction),
        .i_stat        (stat),
        .o_busy        (busy),
        .o_ctl         (ctl)
    );

    tsu_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_ctl       (ctl),
        .i_out_stall (i_out_stall),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .o_out       (o_out)
    );

    assign o_in_stall = busy;

endmodule
`default_nettype wire

// ===== tb/sv/thumb16_store_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thumb16_store_unit_test
// Self-checking bench for the Thumb-16 store/push unit. Register loads and
// store instructions go in on i_in. A scoreboard keeps its own R0-R7/SP/LR and
// queues the store beats each instruction should produce. Every o_out beat is
// checked in order. Stall profiles vary per phase, with one long output hold
// and drain pauses.
// ----------------------------------------------------------------------------
module thumb16_store_unit_test;
    import tsu_pkg::*;

    localparam logic [1:0] SIZE_NONE = 2'd0;
    localparam logic [1:0] SIZE_BYTE = 2'd1;
    localparam logic [1:0] SIZE_HALF = 2'd2;
    localparam logic [1:0] SIZE_WORD = 2'd3;
    localparam logic       FN_LOAD   = 1'b0;
    localparam logic       FN_EXEC   = 1'b1;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 120;
    localparam int SETTLE_CYCLES  = 20;
    localparam int PHASE_ITEMS    = 160;

    class tsu_scoreboard;
        logic [31:0] lo_regs [8];
        logic [31:0] sp;
        logic [31:0] lr;
        t_out        due_stores [$];
        int          n_items;
        int          n_beats;
        int          n_push;
        int          n_err_beats;

        function new();
            foreach (lo_regs[i]) lo_regs[i] = '0;
            sp = '0;
            lr = '0;
            n_items = 0;
            n_beats = 0;
            n_push = 0;
            n_err_beats = 0;
        endfunction

        function int pending();
            return due_stores.size();
        endfunction

        function void add_beat(logic [31:0] addr, logic [31:0] data, logic [1:0] size,
                               logic inval, logic [31:0] npc, logic [31:0] sp_val,
                               t_err err, logic fin);
            t_out b;
            b.store_address    = addr;
            b.store_data       = data;
            b.store_size       = size;
            b.cache_invalidate = inval;
            b.next_pc          = npc;
            b.stack_after      = sp_val;
            b.error_code       = err;
            b.last             = fin;
            due_stores.push_back(b);
        endfunction

        // Applies one accepted beat to the register copy and queues its stores.
        function void note_item(t_in it);
            logic [15:0] ins;
            logic [31:0] npc;
            logic [31:0] sp_new;
            logic [31:0] addr;
            logic [2:0]  rt;
            logic [2:0]  rn;
            logic [2:0]  rm;
            logic [4:0]  imm5;
            int          cnt;
            int          left;
            ins  = it.instruction;
            npc  = it.pc_value + 32'd2;
            rt   = ins[2:0];
            rn   = ins[5:3];
            rm   = ins[8:6];
            imm5 = ins[10:6];
            n_items++;
            if (it.func == FN_LOAD) begin
                if (it.reg_index < REG_SP) begin
                    lo_regs[it.reg_index[2:0]] = it.reg_value;
                end else if (it.reg_index == REG_SP) begin
                    sp = it.reg_value;
                end else if (it.reg_index == REG_LR) begin
                    lr = it.reg_value;
                end
                return;
            end
            if (ins[15:11] == OP5_STR_IMM) begin
                add_beat(lo_regs[rn] + {25'd0, imm5, 2'b00}, lo_regs[rt], SIZE_WORD, 1'b0,
                         npc, sp, ERR_OK, 1'b1);
            end else if (ins[15:11] == OP5_STR_SP) begin
                add_beat(sp + {22'd0, ins[7:0], 2'b00}, lo_regs[ins[10:8]], SIZE_WORD, 1'b0,
                         npc, sp, ERR_OK, 1'b1);
            end else if (ins[15:11] == OP5_STRB_IMM) begin
                add_beat(lo_regs[rn] + {27'd0, imm5}, {24'd0, lo_regs[rt][7:0]}, SIZE_BYTE,
                         1'b0, npc, sp, ERR_OK, 1'b1);
            end else if (ins[15:9] == OP7_STRB_REG) begin
                add_beat(lo_regs[rn] + lo_regs[rm], {24'd0, lo_regs[rt][7:0]}, SIZE_BYTE,
                         1'b0, npc, sp, ERR_OK, 1'b1);
            end else if (ins[15:11] == OP5_STRH_IMM) begin
                add_beat(lo_regs[rn] + {26'd0, imm5, 1'b0}, {16'd0, lo_regs[rt][15:0]},
                         SIZE_HALF, 1'b0, npc, sp, ERR_OK, 1'b1);
            end else if (ins[15:9] == OP7_STRH_REG) begin
                add_beat(lo_regs[rn] + lo_regs[rm], {16'd0, lo_regs[rt][15:0]}, SIZE_HALF,
                         1'b0, npc, sp, ERR_OK, 1'b1);
            end else if (ins[15:9] == OP7_PUSH) begin
                n_push++;
                cnt = ins[8] ? 1 : 0;
                for (int i = 0; i < 8; i++) cnt += ins[i] ? 1 : 0;
                if (cnt == 0) begin
                    n_err_beats++;
                    add_beat('0, '0, SIZE_NONE, 1'b0, npc, sp, ERR_EMPTY, 1'b1);
                    return;
                end
                sp_new = sp - 32'(4 * cnt);
                addr   = sp - 32'd4;
                left   = cnt;
                if (ins[8]) begin
                    left--;
                    add_beat(addr, lr, SIZE_WORD, 1'b1, npc, sp_new, ERR_OK, left == 0);
                    addr -= 32'd4;
                end
                for (int i = 7; i >= 0; i--) begin
                    if (ins[i]) begin
                        left--;
                        add_beat(addr, lo_regs[i], SIZE_WORD, 1'b1, npc, sp_new, ERR_OK,
                                 left == 0);
                        addr -= 32'd4;
                    end
                end
                sp = sp_new;
            end else begin
                n_err_beats++;
                add_beat('0, '0, SIZE_NONE, 1'b0, npc, sp, ERR_BAD, 1'b1);
            end
        endfunction

        function int cmp(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
                return 1;
            end
            return 0;
        endfunction

        // Returns 1 when the beat is unexpected or any field is off.
        function int check_beat(t_out got);
            t_out want;
            int   bad;
            if (due_stores.size() == 0) begin
                $display("%0t: unexpected result beat %h", $time, got);
                return 1;
            end
            want = due_stores.pop_front();
            n_beats++;
            bad = 0;
            bad += cmp("store_address", want.store_address, got.store_address);
            bad += cmp("store_data", want.store_data, got.store_data);
            bad += cmp("store_size", 32'(want.store_size), 32'(got.store_size));
            bad += cmp("cache_invalidate", 32'(want.cache_invalidate),
                       32'(got.cache_invalidate));
            bad += cmp("next_pc", want.next_pc, got.next_pc);
            bad += cmp("stack_after", want.stack_after, got.stack_after);
            bad += cmp("error_code", 32'(want.error_code), 32'(got.error_code));
            bad += cmp("last", 32'(want.last), 32'(got.last));
            return (bad != 0) ? 1 : 0;
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_in_valid;
    logic o_in_stall;
    t_in  i_in;
    logic o_out_valid;
    logic i_out_stall;
    t_out o_out;

    tsu_scoreboard sb;
    int fail_count   = 0;
    int tx_idle_pct  = 0;
    int rx_idle_pct  = 0;
    int hold_asks    = 0;
    int hold_taken   = 0;
    int hold_left    = 0;
    int quiet_cycles = 0;

    thumb16_store_unit u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Output stall: long hold on request, otherwise random per profile.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else if (hold_taken < hold_asks) begin
            hold_taken++;
            hold_left = HOLD_CYCLES - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < rx_idle_pct);
        end
    end

    // Beat monitor and watchdog.
    always @(posedge i_clk) begin
        logic took_in;
        logic took_out;
        if (i_rst_n === 1'b1) begin
            took_in  = i_in_valid && !o_in_stall;
            took_out = o_out_valid && !i_out_stall;
            if (took_in) sb.note_item(i_in);
            if (took_out) fail_count += sb.check_beat(o_out);
            if (took_in || took_out) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no beat moved for %0d cycles, %0d stores outstanding",
                         $time, quiet_cycles, sb.pending());
                $display("** thumb16_store_unit: FAILED **");
                $finish;
            end
        end
    end

    function automatic t_in mk_load(logic [3:0] idx, logic [31:0] val);
        t_in it;
        it.func        = FN_LOAD;
        it.reg_index   = idx;
        it.reg_value   = val;
        it.instruction = 16'($urandom);
        it.pc_value    = $urandom;
        return it;
    endfunction

    function automatic t_in mk_exec(logic [15:0] ins, logic [31:0] pc);
        t_in it;
        it.func        = FN_EXEC;
        it.reg_index   = 4'($urandom);
        it.reg_value   = $urandom;
        it.instruction = ins;
        it.pc_value    = pc;
        return it;
    endfunction

    function automatic logic [31:0] rand_word();
        case ($urandom_range(7))
            0: return 32'h0000_0000;
            1: return 32'hFFFF_FFFF;
            2: return 32'(4 * $urandom_range(9));
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [15:0] rand_store_ins();
        logic [7:0] list;
        case ($urandom_range(9)) inside
            0: return {OP5_STR_IMM, 11'($urandom)};
            1: return {OP5_STR_SP, 11'($urandom)};
            2: return {OP5_STRB_IMM, 11'($urandom)};
            3: return {OP7_STRB_REG, 9'($urandom)};
            4: return {OP5_STRH_IMM, 11'($urandom)};
            5: return {OP7_STRH_REG, 9'($urandom)};
            [6:7]: begin
                if ($urandom_range(11) == 0) return {OP7_PUSH, 9'd0};
                list = 8'($urandom);
                return {OP7_PUSH, 1'($urandom), list};
            end
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic t_in rand_item();
        logic [3:0] idx;
        if ($urandom_range(99) < 35) begin
            if ($urandom_range(9) == 0) begin
                idx = 4'($urandom_range(10, 15));
            end else begin
                idx = 4'($urandom_range(0, 9));
            end
            return mk_load(idx, rand_word());
        end
        return mk_exec(rand_store_ins(), ($urandom_range(15) == 0) ? 32'hFFFF_FFFE : $urandom);
    endfunction

    task automatic offer(input t_in it);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in       <= it;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    task automatic run_random(input int n, input int hold_at, input int pause_at);
        for (int k = 0; k < n; k++) begin
            if (k == pause_at) drain();
            if (k == hold_at) hold_asks++;
            offer(rand_item());
        end
        drain();
    endtask

    initial begin
        t_in directed [$];
        sb = new();
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in        <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        directed.push_back(mk_load(4'd0, 32'hFFFF_FFFF));
        directed.push_back(mk_load(4'd1, 32'h0000_0001));
        directed.push_back(mk_load(4'd2, 32'h8000_0000));
        directed.push_back(mk_load(4'd3, 32'h1234_5678));
        directed.push_back(mk_load(4'd4, 32'hFFFF_FFFC));
        directed.push_back(mk_load(4'd5, 32'h0000_0000));
        directed.push_back(mk_load(4'd6, 32'h0000_ABCD));
        directed.push_back(mk_load(4'd7, 32'h7FFF_FFFF));
        directed.push_back(mk_load(REG_SP, 32'h0000_0008));
        directed.push_back(mk_load(REG_LR, 32'hCAFE_F00D));
        directed.push_back(mk_load(4'd13, 32'h5555_5555));
        directed.push_back(mk_exec({OP5_STR_IMM, 5'd31, 3'd7, 3'd0}, 32'h0000_0000));
        directed.push_back(mk_exec({OP5_STR_SP, 3'd7, 8'hFF}, 32'hFFFF_FFFE));
        directed.push_back(mk_exec({OP5_STRB_IMM, 5'd31, 3'd4, 3'd3}, 32'h0000_1000));
        directed.push_back(mk_exec({OP7_STRB_REG, 3'd4, 3'd2, 3'd6}, 32'h0000_1002));
        directed.push_back(mk_exec({OP5_STRH_IMM, 5'd31, 3'd0, 3'd0}, 32'h0000_1004));
        directed.push_back(mk_exec({OP7_STRH_REG, 3'd0, 3'd0, 3'd3}, 32'h0000_1006));
        directed.push_back(mk_exec({OP7_PUSH, 1'b1, 8'hFF}, 32'h0000_1008));
        directed.push_back(mk_exec({OP7_PUSH, 1'b1, 8'h00}, 32'h0000_100A));
        directed.push_back(mk_exec({OP7_PUSH, 1'b0, 8'h01}, 32'h0000_100C));
        directed.push_back(mk_exec({OP7_PUSH, 1'b0, 8'h80}, 32'h0000_100E));
        directed.push_back(mk_exec({OP7_PUSH, 1'b0, 8'h00}, 32'h0000_1010));
        directed.push_back(mk_exec(16'hFFFF, 32'hFFFF_FFFF));
        directed.push_back(mk_exec(16'h0000, 32'h0000_1014));

        tx_idle_pct = 21;
        rx_idle_pct = 56;
        foreach (directed[i]) offer(directed[i]);
        drain();
        run_random(PHASE_ITEMS, -1, PHASE_ITEMS / 2);

        tx_idle_pct = 56;
        rx_idle_pct = 21;
        run_random(PHASE_ITEMS, -1, -1);

        // No idling; one long output hold while items keep coming.
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        run_random(PHASE_ITEMS, 30, -1);

        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Ran %0d input beats (%0d pushes, %0d error beats), checked %0d store beats",
                 sb.n_items, sb.n_push, sb.n_err_beats, sb.n_beats);
        $display("over three stall profiles with drain pauses and a long output hold.");
        if (fail_count == 0 && sb.pending() == 0) begin
            $display("** thumb16_store_unit: PASSED **");
        end else begin
            $display("** thumb16_store_unit: FAILED **");
        end
        $finish;
    end

endmodule
